[rtl/tpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types, constants and helpers of the texture point address unit.
// ----------------------------------------------------------------------------
package tpa_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned MaxDim    = 16384;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned FracW     = FracBits + 1;   // holds [0, ONE]
  localparam int unsigned SizeW     = 15;
  localparam int unsigned IdxW      = 14;
  localparam int unsigned ProdW     = FracW + SizeW;
  localparam int unsigned ESizeW    = 5;
  localparam int unsigned LinW      = IdxW + SizeW + 1;
  localparam int unsigned OffW      = 32;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned NumStages = 5;

  localparam logic [FracW-1:0] FracOne = FracW'(1) << FracBits;

  typedef enum logic [1:0] {
    MODE_WRAP   = 2'd0,
    MODE_MIRROR = 2'd1,
    MODE_CLAMP  = 2'd2,
    MODE_BORDER = 2'd3
  } tpa_mode_e;

  typedef enum logic [2:0] {
    REG_MODE_U   = 3'd0,
    REG_MODE_V   = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_HEIGHT   = 3'd3,
    REG_PITCH    = 3'd4,
    REG_ELEMSIZE = 3'd5
  } tpa_reg_e;

  typedef struct packed {
    tpa_mode_e          mode_u;
    tpa_mode_e          mode_v;
    logic [SizeW-1:0]   size_u;     // effective width, 1..MaxDim
    logic [SizeW-1:0]   size_v;     // effective height, 1..MaxDim
    logic [SizeW-1:0]   row_pitch;
    logic [ESizeW-1:0]  elem_size;
  } tpa_cfg_t;

  // zero counts as one, anything above the largest texture as the largest
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] raw);
    logic [SizeW-1:0] res;
    if (raw == '0) begin
      res = SizeW'(1);
    end else if (raw > SizeW'(MaxDim)) begin
      res = SizeW'(MaxDim);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage : tpa_pkg
`default_nettype wire

[rtl/tpa_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpa_coord_if / tpa_addr_if
// Valid/ready channels carrying coordinate pairs in and texel addresses out.
// ----------------------------------------------------------------------------
interface tpa_coord_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_u;
  logic signed [31:0] coord_v;

  modport source (output valid, coord_u, coord_v, input ready);
  modport sink   (input valid, coord_u, coord_v, output ready);
endinterface : tpa_coord_if

interface tpa_addr_if;
  logic        valid;
  logic        ready;
  logic [31:0] byte_offset;
  logic [13:0] texel_x;
  logic [13:0] texel_y;
  logic        out_of_bounds;

  modport source (output valid, byte_offset, texel_x, texel_y, out_of_bounds,
                  input ready);
  modport sink   (input valid, byte_offset, texel_x, texel_y, out_of_bounds,
                  output ready);
endinterface : tpa_addr_if
`default_nettype wire

[rtl/tpa_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpa_cfg
// APB register file: address modes, texture size, row pitch, element size.
// ----------------------------------------------------------------------------
module tpa_cfg
  import tpa_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output tpa_cfg_t                 cfg_o
);

  tpa_mode_e         mode_u_q, mode_v_q;
  logic [SizeW-1:0]  width_q, height_q, pitch_q;
  logic [ESizeW-1:0] esize_q;
  logic              wr_en;
  tpa_reg_e          sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = tpa_reg_e'(paddr[ApbAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_u_q <= MODE_WRAP;
      mode_v_q <= MODE_WRAP;
      width_q  <= SizeW'(1);
      height_q <= SizeW'(1);
      pitch_q  <= SizeW'(1);
      esize_q  <= ESizeW'(4);
    end else if (wr_en) begin
      case (sel)
        REG_MODE_U:   mode_u_q <= tpa_mode_e'(pwdata[1:0]);
        REG_MODE_V:   mode_v_q <= tpa_mode_e'(pwdata[1:0]);
        REG_WIDTH:    width_q  <= pwdata[SizeW-1:0];
        REG_HEIGHT:   height_q <= pwdata[SizeW-1:0];
        REG_PITCH:    pitch_q  <= pwdata[SizeW-1:0];
        REG_ELEMSIZE: esize_q  <= pwdata[ESizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (sel)
      REG_MODE_U:   prdata = ApbDataW'(mode_u_q);
      REG_MODE_V:   prdata = ApbDataW'(mode_v_q);
      REG_WIDTH:    prdata = ApbDataW'(width_q);
      REG_HEIGHT:   prdata = ApbDataW'(height_q);
      REG_PITCH:    prdata = ApbDataW'(pitch_q);
      REG_ELEMSIZE: prdata = ApbDataW'(esize_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.mode_u    = mode_u_q;
    cfg_o.mode_v    = mode_v_q;
    cfg_o.size_u    = eff_size(width_q);
    cfg_o.size_v    = eff_size(height_q);
    cfg_o.row_pitch = pitch_q;
    cfg_o.elem_size = esize_q;
  end

endmodule : tpa_cfg
`default_nettype wire

[rtl/tpa_fold.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpa_fold
// Folds one signed fixed-point coordinate into a fraction in [0, ONE].
// ----------------------------------------------------------------------------
module tpa_fold
  import tpa_pkg::*;
(
  input  tpa_mode_e                 mode_i,
  input  wire logic signed [CoordW-1:0] coord_i,
  output logic [FracW-1:0]          frac_o,
  output logic                      oob_o
);

  logic [CoordW-1:0] mag;
  logic [FracW-1:0]  tri_t;
  logic              neg, over;

  assign neg  = coord_i[CoordW-1];
  assign over = !neg && (coord_i[CoordW-2:FracBits] != '0);
  // only the low bits of |c| matter for the period-two reflection
  assign mag   = neg ? (~coord_i + CoordW'(1)) : coord_i;
  assign tri_t = mag[FracW-1:0];

  always_comb begin
    frac_o = '0;
    oob_o  = 1'b0;
    case (mode_i)
      MODE_WRAP:   frac_o = {1'b0, coord_i[FracBits-1:0]};
      MODE_MIRROR: frac_o = (tri_t > FracOne) ? (FracW'(FracOne << 1) - tri_t) : tri_t;
      MODE_CLAMP, MODE_BORDER: begin
        if (neg) begin
          frac_o = '0;
        end else if (over) begin
          frac_o = FracOne - FracW'(1);
        end else begin
          frac_o = {1'b0, coord_i[FracBits-1:0]};
        end
        oob_o = (mode_i == MODE_BORDER) && (neg || over);
      end
      default: frac_o = '0;
    endcase
  end

endmodule : tpa_fold
`default_nettype wire

[rtl/texture_point_address_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// texture_point_address_unit
// Point-sampling texture address unit: fold, scale, floor, byte offset.
// ----------------------------------------------------------------------------
// Takes one coordinate pair and returns its texel column, row, border flag
// and byte offset per clock while not stalled by back-pressure. The five
// stages are: fold by address mode, scale by texel size (17x15 multiply per
// axis), floor and limit to size-1, row times pitch plus column, times element
// size. Back-pressure stalls each stage only while it holds an item, so
// bubbles are squeezed out. Registers are to be written over the APB port while
// no transaction is in flight; the user must keep to it, the unit does not.
// ----------------------------------------------------------------------------
module texture_point_address_unit
  import tpa_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  tpa_coord_if.sink                coord_i,
  tpa_addr_if.source               result_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready
);

  tpa_cfg_t cfg;

  tpa_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  logic [FracW-1:0] fu, fv;
  logic             oob_u, oob_v;

  tpa_fold u_fold_u (.mode_i(cfg.mode_u), .coord_i(coord_i.coord_u),
                     .frac_o(fu), .oob_o(oob_u));
  tpa_fold u_fold_v (.mode_i(cfg.mode_v), .coord_i(coord_i.coord_v),
                     .frac_o(fv), .oob_o(oob_v));

  // stage control
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || result_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign coord_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= coord_i.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // payload
  logic [FracW-1:0] s1_fu_q, s1_fv_q;
  logic             s1_oob_q, s2_oob_q, s3_oob_q, s4_oob_q, s5_oob_q;
  logic [ProdW-1:0] s2_pu_q, s2_pv_q;
  logic [IdxW-1:0]  s3_x_q, s3_y_q, s4_x_q, s4_y_q, s5_x_q, s5_y_q;
  logic [LinW-1:0]  s4_lin_q;
  logic [OffW-1:0]  s5_off_q;

  logic [ProdW-FracBits-1:0] idx_u, idx_v;
  logic [IdxW-1:0]           lim_u, lim_v, x_d, y_d;
  logic [LinW-1:0]           lin_d;
  logic [LinW+ESizeW-1:0]    off_full;

  assign idx_u = s2_pu_q[ProdW-1:FracBits];
  assign idx_v = s2_pv_q[ProdW-1:FracBits];
  assign lim_u = IdxW'(cfg.size_u - SizeW'(1));
  assign lim_v = IdxW'(cfg.size_v - SizeW'(1));
  // mirror edge at exactly one lands on texel size; pull it back inside
  assign x_d = (idx_u > (ProdW-FracBits)'(lim_u)) ? lim_u : idx_u[IdxW-1:0];
  assign y_d = (idx_v > (ProdW-FracBits)'(lim_v)) ? lim_v : idx_v[IdxW-1:0];

  assign lin_d    = LinW'(s3_y_q) * LinW'(cfg.row_pitch) + LinW'(s3_x_q);
  assign off_full = s4_lin_q * cfg.elem_size;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_fu_q  <= fu;
      s1_fv_q  <= fv;
      s1_oob_q <= oob_u | oob_v;
    end
    if (en[1]) begin
      s2_pu_q  <= s1_fu_q * cfg.size_u;
      s2_pv_q  <= s1_fv_q * cfg.size_v;
      s2_oob_q <= s1_oob_q;
    end
    if (en[2]) begin
      s3_x_q   <= x_d;
      s3_y_q   <= y_d;
      s3_oob_q <= s2_oob_q;
    end
    if (en[3]) begin
      s4_lin_q <= lin_d;
      s4_x_q   <= s3_x_q;
      s4_y_q   <= s3_y_q;
      s4_oob_q <= s3_oob_q;
    end
    if (en[4]) begin
      s5_off_q <= off_full[OffW-1:0];
      s5_x_q   <= s4_x_q;
      s5_y_q   <= s4_y_q;
      s5_oob_q <= s4_oob_q;
    end
  end

  assign result_o.valid         = valid_q[NumStages-1];
  assign result_o.byte_offset   = s5_off_q;
  assign result_o.texel_x       = s5_x_q;
  assign result_o.texel_y       = s5_y_q;
  assign result_o.out_of_bounds = s5_oob_q;

endmodule : texture_point_address_unit
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the texture point address unit.
// ----------------------------------------------------------------------------
// Coordinate pairs are queued by the sequence below and driven by a clocked
// driver. Each accepted pair is folded, scaled and turned into a byte offset
// by a local predictor, using a shadow of the sampler registers. A clocked
// monitor compares every result, field by field, with the oldest prediction.
// Registers go in over APB between phases, only once the unit has drained.
// Both sides idle at random; one phase runs flat out, and the result side
// holds off for a long stretch once so that the pipeline backs up.
// ----------------------------------------------------------------------------
module tb_top;
  import tpa_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int ONE            = 1 << FracBits;
  localparam int PHASE_ITEMS    = 160;
  localparam int RANDOM_PHASES  = 12;
  localparam int HOLD_AT        = 900;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic signed [CoordW-1:0] u;
    logic signed [CoordW-1:0] v;
  } coord_pair_t;

  typedef struct packed {
    logic [OffW-1:0] byte_offset;
    logic [IdxW-1:0] x;
    logic [IdxW-1:0] y;
    logic            oob;
  } texel_addr_t;

  typedef struct {
    tpa_mode_e         mode_u;
    tpa_mode_e         mode_v;
    logic [SizeW-1:0]  width;
    logic [SizeW-1:0]  height;
    logic [SizeW-1:0]  pitch;
    logic [ESizeW-1:0] elem_size;
  } sampler_cfg_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  tpa_coord_if coord_if ();
  tpa_addr_if  addr_if ();

  texture_point_address_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coord_i  (coord_if),
    .result_o (addr_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  sampler_cfg_t      sampler_cfg;
  coord_pair_t       pending_coords[$];
  texel_addr_t       expected_addrs[$];
  int                coords_queued;
  int                coords_sent;
  int                error_count;
  bit                steady;
  logic signed [31:0] corner_coords[12];

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint unsigned fold_coord(input tpa_mode_e mode,
                                                 input logic signed [CoordW-1:0] c,
                                                 output logic oob);
    longint          cs;
    longint unsigned one;
    longint unsigned mag;
    longint unsigned t;
    longint unsigned f;
    cs  = c;
    one = longint'(ONE);
    oob = 1'b0;
    case (mode)
      MODE_WRAP: begin
        f = cs & (one - 1);
      end
      MODE_MIRROR: begin
        mag = (cs < 0) ? -cs : cs;
        t   = mag & (2 * one - 1);
        f   = (t > one) ? 2 * one - t : t;
      end
      default: begin
        if (cs < 0) begin
          f   = 0;
          oob = (mode == MODE_BORDER);
        end else if (cs >= one) begin
          f   = one - 1;
          oob = (mode == MODE_BORDER);
        end else begin
          f = cs;
        end
      end
    endcase
    return f;
  endfunction

  // zero counts as one texel, oversize registers as the largest texture
  function automatic logic [IdxW-1:0] texel_index(input longint unsigned f,
                                                   input logic [SizeW-1:0] raw);
    longint unsigned lim;
    longint unsigned idx;
    if (raw == '0) begin
      lim = 1;
    end else if (raw > MaxDim) begin
      lim = MaxDim;
    end else begin
      lim = raw;
    end
    idx = (f * lim) >> FracBits;
    if (idx > lim - 1) begin
      idx = lim - 1;
    end
    return idx[IdxW-1:0];
  endfunction

  function automatic texel_addr_t predict_address(input coord_pair_t p,
                                                  input sampler_cfg_t cfg);
    texel_addr_t     a;
    logic            oob_u;
    logic            oob_v;
    longint unsigned fu;
    longint unsigned fv;
    longint unsigned lin;
    fu  = fold_coord(cfg.mode_u, p.u, oob_u);
    fv  = fold_coord(cfg.mode_v, p.v, oob_v);
    a.x = texel_index(fu, cfg.width);
    a.y = texel_index(fv, cfg.height);
    lin = (longint'(a.y) * cfg.pitch + a.x) * cfg.elem_size;
    a.byte_offset = lin[OffW-1:0];
    a.oob = oob_u | oob_v;
    return a;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // --------------------------------------------------------------------------
  // Coordinate driver
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    coord_pair_t p;
    if (!rst_ni) begin
      coord_if.valid   <= 1'b0;
      coord_if.coord_u <= '0;
      coord_if.coord_v <= '0;
    end else begin
      if (coord_if.valid && coord_if.ready) begin
        p.u = coord_if.coord_u;
        p.v = coord_if.coord_v;
        expected_addrs.push_back(predict_address(p, sampler_cfg));
        coords_sent++;
      end
      if (!coord_if.valid || coord_if.ready) begin
        if (pending_coords.size() != 0 && (steady || $urandom_range(0, 99) >= 30)) begin
          p = pending_coords.pop_front();
          coord_if.valid   <= 1'b1;
          coord_if.coord_u <= p.u;
          coord_if.coord_v <= p.v;
        end else begin
          coord_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and back-pressure
  // --------------------------------------------------------------------------
  int rx_hold;
  bit hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    texel_addr_t got;
    texel_addr_t want;
    if (!rst_ni) begin
      addr_if.ready <= 1'b0;
      rx_hold       <= 0;
      hold_done     <= 1'b0;
    end else begin
      if (addr_if.valid && addr_if.ready) begin
        got.byte_offset = addr_if.byte_offset;
        got.x           = addr_if.texel_x;
        got.y           = addr_if.texel_y;
        got.oob         = addr_if.out_of_bounds;
        if (expected_addrs.size() == 0) begin
          flag_error($sformatf("unexpected transaction off=%h x=%0d y=%0d oob=%b",
                               got.byte_offset, got.x, got.y, got.oob));
        end else begin
          want = expected_addrs.pop_front();
          if (got.byte_offset !== want.byte_offset)
            flag_error($sformatf("byte_offset exp %h got %h",
                                 want.byte_offset, got.byte_offset));
          if (got.x !== want.x)
            flag_error($sformatf("texel_x exp %0d got %0d", want.x, got.x));
          if (got.y !== want.y)
            flag_error($sformatf("texel_y exp %0d got %0d", want.y, got.y));
          if (got.oob !== want.oob)
            flag_error($sformatf("out_of_bounds exp %b got %b", want.oob, got.oob));
        end
      end
      // one long hold-off so the pipeline fills and stalls its input
      if (rx_hold != 0) begin
        rx_hold       <= rx_hold - 1;
        addr_if.ready <= 1'b0;
      end else if (!hold_done && coords_sent >= HOLD_AT) begin
        hold_done     <= 1'b1;
        rx_hold       <= HOLD_CYCLES;
        addr_if.ready <= 1'b0;
      end else begin
        addr_if.ready <= steady || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles without any transaction
  // --------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (coord_if.valid && coord_if.ready) || (addr_if.valid && addr_if.ready)
        || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Register access and sequence helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input tpa_reg_e idx, input logic [ApbDataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE_U:   sampler_cfg.mode_u    = tpa_mode_e'(val[1:0]);
      REG_MODE_V:   sampler_cfg.mode_v    = tpa_mode_e'(val[1:0]);
      REG_WIDTH:    sampler_cfg.width     = val[SizeW-1:0];
      REG_HEIGHT:   sampler_cfg.height    = val[SizeW-1:0];
      REG_PITCH:    sampler_cfg.pitch     = val[SizeW-1:0];
      REG_ELEMSIZE: sampler_cfg.elem_size = val[ESizeW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_sampler(input tpa_mode_e mu, input tpa_mode_e mv,
                                 input int w, input int h, input int pitch, input int es);
    write_reg(REG_MODE_U, ApbDataW'(mu));
    write_reg(REG_MODE_V, ApbDataW'(mv));
    write_reg(REG_WIDTH, ApbDataW'(w));
    write_reg(REG_HEIGHT, ApbDataW'(h));
    write_reg(REG_PITCH, ApbDataW'(pitch));
    write_reg(REG_ELEMSIZE, ApbDataW'(es));
  endtask

  task automatic queue_coord(input logic signed [31:0] u, input logic signed [31:0] v);
    coord_pair_t p;
    p.u = u;
    p.v = v;
    pending_coords.push_back(p);
    coords_queued++;
  endtask

  // every prediction retired, then a pipeline's worth of slack
  task automatic drain();
    while (coords_sent != coords_queued || expected_addrs.size() != 0) @(posedge clk_i);
    repeat (NumStages + 2) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] random_coord();
    int k;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return int'($urandom_range(0, 6 * ONE)) - 3 * ONE;
      2: begin
        k = int'($urandom_range(0, 8)) - 4;
        return k * ONE + int'($urandom_range(0, 2)) - 1;
      end
      default: return int'($urandom_range(0, ONE - 1));
    endcase
  endfunction

  function automatic int random_size(input int hi);
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, hi));
    return int'($urandom_range(1, 64));
  endfunction

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    coord_if.valid   = 1'b0;
    coord_if.coord_u = '0;
    coord_if.coord_v = '0;
    addr_if.ready    = 1'b0;
    steady           = 1'b0;
    coords_queued    = 0;
    coords_sent      = 0;
    error_count      = 0;
    sampler_cfg      = '{MODE_WRAP, MODE_WRAP, SizeW'(1), SizeW'(1), SizeW'(1), ESizeW'(4)};
    corner_coords    = '{0, 1, ONE - 1, ONE, ONE + 1, -1, -ONE, 2 * ONE - 1, 2 * ONE,
                         3 * ONE / 2, 32'h7FFF_FFFF, 32'h8000_0000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // mirror edge at one on the largest texture, border flag on both sides of V
    program_sampler(MODE_MIRROR, MODE_BORDER, MaxDim, MaxDim, MaxDim, 16);
    foreach (corner_coords[i]) queue_coord(corner_coords[i], corner_coords[i]);
    drain();
    program_sampler(MODE_CLAMP, MODE_WRAP, 1, 7, 3, 1);
    foreach (corner_coords[i]) queue_coord(corner_coords[i], corner_coords[11 - i]);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: program_sampler(MODE_WRAP, MODE_MIRROR, 0, 32767, 0, 31);
        1: program_sampler(MODE_BORDER, MODE_CLAMP, MaxDim, 1, 32767, 0);
        2: program_sampler(MODE_MIRROR, MODE_BORDER, 640, 480, 640, 4);
        3: program_sampler(MODE_BORDER, MODE_BORDER, 32767, 0, 32767, 31);
        default: program_sampler(tpa_mode_e'($urandom_range(0, 3)),
                                 tpa_mode_e'($urandom_range(0, 3)),
                                 random_size(32767), random_size(32767),
                                 random_size(32767), int'($urandom_range(0, 31)));
      endcase
      steady = (ph == 4);
      repeat (PHASE_ITEMS) queue_coord(random_coord(), random_coord());
      drain();
      steady = 1'b0;
    end

    repeat (NumStages * 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : tb_top

[texture_point_address_unit.f]
rtl/tpa_pkg.sv
rtl/tpa_if.sv
rtl/tpa_cfg.sv
rtl/tpa_fold.sv
rtl/texture_point_address_unit.sv
test/tb_top.sv
